// File: src/bpeg_pkg.sv
package bpeg_pkg;

    localparam int BYTE_BITS    = 8;
    localparam int RAW_MAX_BITS = 32;
    localparam int WORD_BITS    = 33;
    localparam int PEND_BITS    = 7;
    localparam int STREAM_BITS  = 72;
    localparam int LEN_BITS     = 6;
    localparam int TOTAL_BITS   = 7;

    localparam logic [1:0] ACT_RAW  = 2'd0;
    localparam logic [1:0] ACT_UE   = 2'd1;
    localparam logic [1:0] ACT_SE   = 2'd2;
    localparam logic [1:0] ACT_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] value;
        logic [5:0]         bit_count;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_out_item;

    // Request to the normalizing shifter.
    typedef struct packed {
        logic                 start;
        logic                 ue;
        logic [WORD_BITS-1:0] word;
        logic [LEN_BITS-1:0]  cnt;
    } t_norm_req;

    // Status back from the normalizing shifter.
    typedef struct packed {
        logic                 done;
        logic [WORD_BITS-1:0] word;
        logic [LEN_BITS-1:0]  len;
    } t_norm_res;

endpackage

// File: src/bpeg_norm.sv
module bpeg_norm
    import bpeg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_norm_req i_req,
    output t_norm_res o_res
);

    logic                 r_busy;
    logic                 r_ue;
    logic [WORD_BITS-1:0] r_word;
    logic [LEN_BITS-1:0]  r_len;
    logic [LEN_BITS-1:0]  r_cnt;

    logic stop;
    logic big_step;

    // Exp-Golomb words stop at their leading one; raw words stop at the requested length.
    always_comb begin
        if (r_ue) begin
            stop     = r_word[WORD_BITS-1];
            big_step = (r_word[WORD_BITS-1 -: BYTE_BITS] == '0);
        end else begin
            stop     = (r_len == r_cnt);
            big_step = ({1'b0, r_len} >= ({1'b0, r_cnt} + (LEN_BITS+1)'(BYTE_BITS)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && stop) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_ue   <= i_req.ue;
            r_word <= i_req.word;
            r_len  <= LEN_BITS'(WORD_BITS);
            r_cnt  <= i_req.cnt;
        end else if (r_busy && !stop) begin
            if (big_step) begin
                r_word <= r_word << BYTE_BITS;
                r_len  <= r_len - LEN_BITS'(BYTE_BITS);
            end else begin
                r_word <= r_word << 1;
                r_len  <= r_len - LEN_BITS'(1);
            end
        end
    end

    assign o_res.done = r_busy && stop;
    assign o_res.word = r_word;
    assign o_res.len  = r_len;

endmodule

// File: src/bit_packer_exp_golomb_encoder_unit.sv
// MSB-first bit packer with order-0 Exp-Golomb coding.
//
// The input channel (i_in_valid, o_in_stall, i_in_data) takes one write request per
// transfer: a raw write of the low bit_count bits of value (at most 32), an unsigned Exp-Golomb
// write, or a signed Exp-Golomb write. Action code 3 is taken and dropped.
// The output channel (o_out_valid, i_out_stall, o_out_data) delivers each completed
// byte, earliest bit in bit 7, with last_byte set on the final byte of a request.
// A request that completes no byte produces no transfer; its bits wait internally.
//
// One request is worked on at a time. After acceptance a shared shifter normalizes
// the code word, eight or one bit per step; the build state then lines the word up
// behind the pending bits, and then one byte leaves per cycle while the receiver does
// not stall, until the bits that do not fill a byte are kept as pending bits and the
// block returns to idle. A dropped request leaves the block idle and ready.
// A stalled receiver holds the output register and the byte sequencer with it.
// Synchronous reset clears the pending bits, the sequencer and the output valid.
module bit_packer_exp_golomb_encoder_unit
    import bpeg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_NORM  = 4'b0010,
        ST_BUILD = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Leftover bits are kept left-aligned; only the top r_pc bits are valid, the rest are zero.
    logic [PEND_BITS-1:0]   r_pend, n_pend;
    logic [2:0]             r_pc, n_pc;
    logic                   r_ue, n_ue;
    logic [STREAM_BITS-1:0] r_stream, n_stream;
    logic [TOTAL_BITS-1:0]  r_total, n_total;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out, n_out;

    t_norm_req norm_req;
    t_norm_res norm_res;

    logic                 in_xfer;
    logic                 out_free;
    logic [5:0]           raw_cnt;
    logic [31:0]          neg_mag;
    logic [WORD_BITS-1:0] start_word;
    logic [LEN_BITS-1:0]  zero_cnt;
    logic [5:0]           shamt;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // The code word handed to the shifter: raw bits, value+1, or the mapped signed number plus one.
    always_comb begin
        raw_cnt = (i_in_data.bit_count > 6'(RAW_MAX_BITS)) ? 6'(RAW_MAX_BITS)
                                                           : i_in_data.bit_count;
        neg_mag = ~i_in_data.value + 32'd1;
        case (i_in_data.action)
            ACT_UE: begin
                start_word = {1'b0, i_in_data.value} + WORD_BITS'(1);
            end
            ACT_SE: begin
                if (i_in_data.value[31]) begin
                    start_word = {neg_mag, 1'b1};
                end else if (i_in_data.value == '0) begin
                    start_word = WORD_BITS'(1);
                end else begin
                    start_word = {i_in_data.value, 1'b0};
                end
            end
            default: begin
                start_word = {1'b0, i_in_data.value};
            end
        endcase
    end

    assign norm_req.start = in_xfer && (i_in_data.action != ACT_NONE);
    assign norm_req.ue    = (i_in_data.action != ACT_RAW);
    assign norm_req.word  = start_word;
    assign norm_req.cnt   = raw_cnt;

    bpeg_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (norm_req),
        .o_res   (norm_res)
    );

    // An Exp-Golomb word of n bits is preceded by n-1 zeros; a raw word by none.
    assign zero_cnt = r_ue ? (norm_res.len - LEN_BITS'(1)) : '0;
    assign shamt    = 6'(r_pc) + zero_cnt;

    always_comb begin
        n_state     = r_state;
        n_pend      = r_pend;
        n_pc        = r_pc;
        n_ue        = r_ue;
        n_stream    = r_stream;
        n_total     = r_total;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        case (r_state)
            ST_IDLE: begin
                if (norm_req.start) begin
                    n_ue    = norm_req.ue;
                    n_state = ST_NORM;
                end
            end
            ST_NORM: begin
                if (norm_res.done) begin
                    n_state = ST_BUILD;
                end
            end
            ST_BUILD: begin
                n_stream = ({norm_res.word, (STREAM_BITS-WORD_BITS)'(0)} >> shamt)
                         | {r_pend, (STREAM_BITS-PEND_BITS)'(0)};
                n_total  = TOTAL_BITS'(r_pc) + TOTAL_BITS'(zero_cnt)
                         + TOTAL_BITS'(norm_res.len);
                n_state  = ST_EMIT;
            end
            ST_EMIT: begin
                if (r_total < TOTAL_BITS'(BYTE_BITS)) begin
                    n_pend  = r_stream[STREAM_BITS-1 -: PEND_BITS];
                    n_pc    = r_total[2:0];
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.out_byte  = r_stream[STREAM_BITS-1 -: BYTE_BITS];
                    n_out.last_byte = (r_total < TOTAL_BITS'(2*BYTE_BITS));
                    n_stream        = r_stream << BYTE_BITS;
                    n_total         = r_total - TOTAL_BITS'(BYTE_BITS);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend      <= '0;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ue     <= n_ue;
        r_stream <= n_stream;
        r_total  <= n_total;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: src/bpeg_checker.sv
module bpeg_checker
    import bpeg_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // A byte held by the receiver stays on the port unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output byte changed or dropped");

    // A write request keeps the block busy in the following cycle.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_data.action != ACT_NONE) |=> o_in_stall)
        else $error("block ready right after taking a write");

    // After a byte that is not the last of its request, the block is still busy.
    a_more_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_data.last_byte |=> o_in_stall)
        else $error("block ready in the middle of a byte sequence");

    // While ready for a new request, only a final byte may still be waiting.
    a_idle_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !(o_out_valid && !o_out_data.last_byte))
        else $error("non-final byte pending while ready");

endmodule

bind bit_packer_exp_golomb_encoder_unit bpeg_checker u_bpeg_checker (.*);
